FILE: rtl/ean13_pkg.sv
`timescale 1ns / 1ps

package ean13_pkg;

  localparam int QueueDepth = 4;

  localparam logic [6:0] StartGuard  = 7'h05;
  localparam logic [6:0] CenterGuard = 7'h0A;
  localparam logic [6:0] EndGuard    = 7'h05;
  localparam logic [2:0] GuardLen    = 3'd3;
  localparam logic [2:0] CenterLen   = 3'd5;
  localparam logic [2:0] DigitLen    = 3'd7;

  // what the back end has to draw for one accepted digit
  typedef enum logic [2:0] {
    JOB_START    = 3'd0,  // lead digit: start guard only
    JOB_LEFT     = 3'd1,  // left-half digit, center guard after the sixth
    JOB_RIGHT    = 3'd2,  // right-half digit
    JOB_APPEND   = 3'd3,  // twelfth digit, then check digit and end guard
    JOB_VALIDATE = 3'd4   // supplied check digit, then end guard
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [3:0]  digit;
    logic        use_g;
    logic        center;
    logic [3:0]  check;
    logic        error;
  } job_t;

  function automatic logic [6:0] code_l(input logic [3:0] d);
    logic [6:0] c;
    case (d)
      4'd0: c = 7'h0D;
      4'd1: c = 7'h19;
      4'd2: c = 7'h13;
      4'd3: c = 7'h3D;
      4'd4: c = 7'h23;
      4'd5: c = 7'h31;
      4'd6: c = 7'h2F;
      4'd7: c = 7'h3B;
      4'd8: c = 7'h37;
      default: c = 7'h0B;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] code_g(input logic [3:0] d);
    logic [6:0] c;
    case (d)
      4'd0: c = 7'h27;
      4'd1: c = 7'h33;
      4'd2: c = 7'h1B;
      4'd3: c = 7'h21;
      4'd4: c = 7'h1D;
      4'd5: c = 7'h39;
      4'd6: c = 7'h05;
      4'd7: c = 7'h11;
      4'd8: c = 7'h09;
      default: c = 7'h17;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] code_r(input logic [3:0] d);
    logic [6:0] c;
    case (d)
      4'd0: c = 7'h72;
      4'd1: c = 7'h66;
      4'd2: c = 7'h6C;
      4'd3: c = 7'h42;
      4'd4: c = 7'h5C;
      4'd5: c = 7'h4E;
      4'd6: c = 7'h50;
      4'd7: c = 7'h44;
      4'd8: c = 7'h48;
      default: c = 7'h74;
    endcase
    return c;
  endfunction

  // bit (5 - k) set: left digit k uses the g code
  function automatic logic [5:0] parity_g(input logic [3:0] lead);
    logic [5:0] p;
    case (lead)
      4'd0: p = 6'h00;
      4'd1: p = 6'h0B;
      4'd2: p = 6'h0D;
      4'd3: p = 6'h0E;
      4'd4: p = 6'h13;
      4'd5: p = 6'h19;
      4'd6: p = 6'h1C;
      4'd7: p = 6'h15;
      4'd8: p = 6'h16;
      default: p = 6'h1A;
    endcase
    return p;
  endfunction

endpackage

FILE: rtl/ean13_barcode_encoder_core.sv
`timescale 1ns / 1ps
// path: an accepted digit is first written into the job queue, and its first pattern word
//   is then captured in the output register before it is handed off
// throughput: one pattern word per cycle unless out_ready stalls the output register;
//   a digit gives one to three words (three for the twelfth digit in append mode)
// a four-entry job queue sits between digit intake and pattern expansion
// reset (synchronous, rst high): position, residue and lead digit clear, append mode on

module ean13_barcode_encoder_core #(
  parameter int QUEUE_DEPTH = ean13_pkg::QueueDepth
) (
  input  logic       clk,
  input  logic       rst,
  // configuration: append_check
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  // digit words
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [3:0] digit,
  // pattern words
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] pattern,
  output logic [2:0] pattern_length,
  output logic [3:0] check_value,
  output logic       check_error,
  output logic       is_last
);

  ean13_pkg::job_t job;
  ean13_pkg::job_t head_job;
  logic            push;
  logic            full;
  logic            head_valid;
  logic            pop;

  // intake only stalls when the job queue is full, never on the output side directly
  assign in_ready = !full;
  assign push     = in_valid && in_ready;

  // front: tracks position, lead digit and weighted residue, turns each digit
  // into a job that already carries parity choice, check digit and error
  ean13_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .digit     (digit),
    .job       (job)
  );

  // short job queue decouples intake from expansion
  ean13_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (job),
    .full       (full),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  // back: expands each job into one to three pattern words
  ean13_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head_job       (head_job),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pattern        (pattern),
    .pattern_length (pattern_length),
    .check_value    (check_value),
    .check_error    (check_error),
    .is_last        (is_last)
  );

endmodule

FILE: rtl/ean13_front.sv
`timescale 1ns / 1ps

module ean13_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               push,
  input  logic [3:0]         digit,
  output ean13_pkg::job_t    job
);

  logic       append_check;
  logic [3:0] position;
  logic [3:0] lead_digit;
  logic [3:0] weighted_residue;

  logic [3:0] d;
  logic [3:0] pos;
  logic [5:0] term;
  logic [5:0] sum;
  logic [3:0] residue_next;
  logic [3:0] position_next;
  logic [5:0] parity;
  logic [2:0] parity_sel;

  function automatic logic [3:0] check_of(input logic [3:0] r);
    return (r == 4'd0) ? 4'd0 : 4'(4'd10 - r);
  endfunction

  always_comb begin
    d          = (digit > 4'd9) ? 4'd9 : digit;
    pos        = (position > 4'd12) ? 4'd0 : position;
    term       = pos[0] ? (6'(d) + {1'b0, d, 1'b0}) : 6'(d);
    sum        = 6'(weighted_residue) + term;
    // sum stays below 40, so three compares finish the mod 10
    if (sum >= 6'd30) begin
      residue_next = 4'(sum - 6'd30);
    end else if (sum >= 6'd20) begin
      residue_next = 4'(sum - 6'd20);
    end else if (sum >= 6'd10) begin
      residue_next = 4'(sum - 6'd10);
    end else begin
      residue_next = 4'(sum);
    end
    parity     = ean13_pkg::parity_g(lead_digit);
    parity_sel = 3'(4'd6 - pos);

    job.digit  = d;
    job.use_g  = 1'b0;
    job.center = 1'b0;
    job.check  = 4'd0;
    job.error  = 1'b0;
    position_next = 4'(pos + 4'd1);
    if (pos == 4'd12) begin
      job.kind      = ean13_pkg::JOB_VALIDATE;
      job.check     = check_of(weighted_residue);
      job.error     = (d != check_of(weighted_residue));
      position_next = 4'd0;
    end else if (pos == 4'd0) begin
      job.kind = ean13_pkg::JOB_START;
    end else if (pos <= 4'd6) begin
      job.kind   = ean13_pkg::JOB_LEFT;
      job.use_g  = parity[parity_sel];
      job.center = (pos == 4'd6);
    end else if (pos == 4'd11 && append_check) begin
      job.kind      = ean13_pkg::JOB_APPEND;
      job.check     = check_of(residue_next);
      position_next = 4'd0;
    end else begin
      job.kind = ean13_pkg::JOB_RIGHT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      append_check     <= 1'b1;
      position         <= 4'd0;
      lead_digit       <= 4'd0;
      weighted_residue <= 4'd0;
    end else begin
      if (cfg_we) begin
        append_check <= cfg_wdata;
      end
      if (push) begin
        position <= position_next;
        if (position_next == 4'd0) begin
          weighted_residue <= 4'd0;
        end else begin
          weighted_residue <= residue_next;
        end
        if (pos == 4'd0) begin
          lead_digit <= d;
        end
      end
    end
  end

  a_position_range: assert property (@(posedge clk) disable iff (rst)
    position <= 4'd12) else $error("position out of range");

  a_validate_ends_code: assert property (@(posedge clk) disable iff (rst)
    push && job.kind == ean13_pkg::JOB_VALIDATE |=> position == 4'd0 &&
      weighted_residue == 4'd0) else $error("code did not restart after check digit");

endmodule

FILE: rtl/ean13_queue.sv
`timescale 1ns / 1ps

module ean13_queue #(
  parameter int DEPTH = ean13_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ean13_pkg::job_t    push_job,
  output logic               full,
  output logic               head_valid,
  output ean13_pkg::job_t    head_job,
  input  logic               pop
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ean13_pkg::job_t mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CW'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CW'(count - 1'b1);
      end
    end
  end

  a_no_empty_pop: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0) else $error("pop from empty queue");

endmodule

FILE: rtl/ean13_back.sv
`timescale 1ns / 1ps

module ean13_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  ean13_pkg::job_t    head_job,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [6:0]         pattern,
  output logic [2:0]         pattern_length,
  output logic [3:0]         check_value,
  output logic               check_error,
  output logic               is_last
);

  logic [1:0] step;
  logic       load;
  logic       last_step;
  logic [6:0] pat;
  logic [2:0] len;
  logic [3:0] chk;
  logic       err;
  logic       last;

  always_comb begin
    pat       = ean13_pkg::code_r(head_job.digit);
    len       = ean13_pkg::DigitLen;
    chk       = 4'd0;
    err       = 1'b0;
    last      = 1'b0;
    last_step = 1'b1;
    case (head_job.kind)
      ean13_pkg::JOB_START: begin
        pat = ean13_pkg::StartGuard;
        len = ean13_pkg::GuardLen;
      end
      ean13_pkg::JOB_LEFT: begin
        if (step == 2'd0) begin
          pat       = head_job.use_g ? ean13_pkg::code_g(head_job.digit)
                                     : ean13_pkg::code_l(head_job.digit);
          last_step = !head_job.center;
        end else begin
          pat = ean13_pkg::CenterGuard;
          len = ean13_pkg::CenterLen;
        end
      end
      ean13_pkg::JOB_RIGHT: begin
        last_step = 1'b1;
      end
      ean13_pkg::JOB_APPEND: begin
        if (step == 2'd0) begin
          last_step = 1'b0;
        end else if (step == 2'd1) begin
          pat       = ean13_pkg::code_r(head_job.check);
          last_step = 1'b0;
        end else begin
          pat  = ean13_pkg::EndGuard;
          len  = ean13_pkg::GuardLen;
          chk  = head_job.check;
          last = 1'b1;
        end
      end
      ean13_pkg::JOB_VALIDATE: begin
        if (step == 2'd0) begin
          last_step = 1'b0;
        end else begin
          pat  = ean13_pkg::EndGuard;
          len  = ean13_pkg::GuardLen;
          chk  = head_job.check;
          err  = head_job.error;
          last = 1'b1;
        end
      end
      default: begin
        last_step = 1'b1;
      end
    endcase
  end

  assign load = head_valid && (!out_valid || out_ready);
  assign pop  = load && last_step;

  always_ff @(posedge clk) begin
    if (load) begin
      pattern        <= pat;
      pattern_length <= len;
      check_value    <= chk;
      check_error    <= err;
      is_last        <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        step      <= last_step ? 2'd0 : 2'(step + 2'd1);
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    step != 2'd3) else $error("step counter out of range");

  a_mid_job_held: assert property (@(posedge clk) disable iff (rst)
    step != 2'd0 |-> head_valid) else $error("job left the queue mid-expansion");

  a_last_is_guard: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_last |-> pattern_length == ean13_pkg::GuardLen &&
      pattern == ean13_pkg::EndGuard) else $error("final word is not an end guard");

endmodule
